// ===== rtl/core/hsuc_pkg.sv =====
// types and constants shared by the unit converter modules
// no dependencies

package hsuc_pkg;

    // conversion selector codes
    localparam logic [3:0] CMD_IN_FROM      = 4'd0;
    localparam logic [3:0] CMD_IN_TO        = 4'd1;
    localparam logic [3:0] CMD_IN5_FROM     = 4'd2;
    localparam logic [3:0] CMD_IN5_TO       = 4'd3;
    localparam logic [3:0] CMD_DIODE8_FROM  = 4'd4;
    localparam logic [3:0] CMD_DIODE10_FROM = 4'd5;
    localparam logic [3:0] CMD_DIODE_TO     = 4'd6;
    localparam logic [3:0] CMD_THERM_FROM   = 4'd7;
    localparam logic [3:0] CMD_THERM_TO     = 4'd8;
    localparam logic [3:0] CMD_FAN_FROM     = 4'd9;
    localparam logic [3:0] CMD_FAN_TO       = 4'd10;

    // divider geometry: quotient bits (one cell each), divisor and remainder bits
    localparam int QW = 21;
    localparam int DW = 24;
    localparam int NW = QW + DW;

    // conversion constants
    localparam logic signed [23:0] FAN_NUM   = 24'sd1310720;
    localparam logic [19:0]        RPM_MAX   = 20'd1000000;

    // what happens to the quotient after the divider
    typedef enum logic [2:0] {
        POST_PLAIN,
        POST_ADD3_CLAMP,
        POST_CLAMP,
        POST_SUB253_CLAMP,
        POST_FAN_CLAMP,
        POST_ZERO,
        POST_BAD
    } post_t;

    // word moving down the divider chain
    typedef struct packed {
        logic          valid;
        logic [DW-1:0] rem;
        logic [QW-1:0] num;
        logic [QW-1:0] quo;
        logic [DW-1:0] den;
        logic          neg;
        post_t         post;
    } div_stage_t;

endpackage

// ===== rtl/core/hsuc_div_cell.sv =====
// one restoring division cell: produces one quotient bit per word
// depends on hsuc_pkg

module hsuc_div_cell
    import hsuc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  div_stage_t stage_in,
    output div_stage_t stage_out
);

    div_stage_t    stage_reg;
    div_stage_t    stage_next;
    logic [DW:0]   trial;
    logic          ge;

    // shift in the next numerator bit and try to subtract the divisor
    always_comb begin
        trial = {stage_in.rem, stage_in.num[QW-1]};
        ge = trial >= {1'b0, stage_in.den};
        stage_next = stage_in;
        stage_next.rem = ge ? DW'(trial - {1'b0, stage_in.den}) : trial[DW-1:0];
        stage_next.num = {stage_in.num[QW-2:0], 1'b0};
        stage_next.quo = {stage_in.quo[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/core/hwmon_sensor_unit_converter.sv =====
// top level of the hardware-monitor unit converter
// depends on hsuc_pkg and hsuc_div_cell

// Takes one word per clock while not stalled and returns one result word per input
// word, in order. The path runs through the operand select register, one
// multiply-add register, a chain of 21 division cells (one quotient bit per
// cell) and the output register. The pipeline moves as a whole while the output
// register is empty or being taken; a one-word skid register on the input keeps
// s_tready registered, so one more word is taken while a result waits.

module hwmon_sensor_unit_converter
    import hsuc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_code[9:0], physical_value[30:10], fan_div_code[32:31]
    input  logic [3:0]  s_tuser,   // cmd[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // value[21:0]
    output logic [0:0]  m_tuser    // bad_cmd[0]
);

    typedef struct packed {
        logic               valid;
        logic signed [23:0] a;
        logic signed [16:0] k;
        logic signed [15:0] off;
        logic [DW-1:0]      den;
        post_t              post;
    } front_t;

    typedef struct packed {
        logic               valid;
        logic signed [NW-1:0] n;
        logic [DW-1:0]      den;
        post_t              post;
    } prod_t;

    logic        en;
    logic        skid_valid_reg, skid_valid_next;
    logic [32:0] skid_data_reg;
    logic [3:0]  skid_user_reg;
    logic        in_valid;
    logic [32:0] in_data;
    logic [3:0]  in_user;

    front_t      front_reg, front_next;
    prod_t       prod_reg, prod_next;
    logic signed [40:0] prod;
    logic [NW-1:0] mag;

    div_stage_t  chain [QW+1];

    logic        out_valid_reg;
    logic [21:0] out_value_reg, out_value_next;
    logic        out_bad_reg, out_bad_next;

    // whole pipeline advances when the output register can take a word
    assign en = !out_valid_reg || m_tready;
    assign s_tready = !skid_valid_reg;

    // skid register holds a word taken while the pipeline is stalled
    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (en) begin
            skid_valid_next = 1'b0;
        end else if (s_tvalid && s_tready) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_tvalid && s_tready) begin
            skid_data_reg <= s_tdata[32:0];
            skid_user_reg <= s_tuser;
        end
    end

    assign in_valid = skid_valid_reg || (s_tvalid && s_tready);
    assign in_data  = skid_valid_reg ? skid_data_reg : s_tdata[32:0];
    assign in_user  = skid_valid_reg ? skid_user_reg : s_tuser;

    // operand select: every conversion becomes (a * k + off) / den
    always_comb begin
        logic [9:0]         r;
        logic signed [20:0] v;
        logic [1:0]         dc;
        logic signed [23:0] rs;
        logic signed [23:0] vs;
        logic [19:0]        t;
        logic [22:0]        td;
        r  = in_data[9:0];
        v  = in_data[30:10];
        dc = in_data[32:31];
        rs = {14'b0, r};
        vs = {{3{v[20]}}, v};
        if (v < 21'sd1) begin
            t = 20'd1;
        end else if ({1'b0, v[19:0]} > {1'b0, RPM_MAX}) begin
            t = RPM_MAX;
        end else begin
            t = v[19:0];
        end
        td = {3'b0, t} << dc;

        front_next.valid = in_valid;
        front_next.a     = 24'sd0;
        front_next.k     = 17'sd0;
        front_next.off   = 16'sd0;
        front_next.den   = DW'(1);
        front_next.post  = POST_PLAIN;
        case (in_user)
            CMD_IN_FROM: begin
                front_next.a = rs - 24'sd3;
                front_next.k = 17'sd1000;
                front_next.off = 16'sd479;
                front_next.den = DW'(958);
            end
            CMD_IN_TO: begin
                front_next.a = vs;
                front_next.k = 17'sd958;
                front_next.off = 16'sd500;
                front_next.den = DW'(1000);
                front_next.post = POST_ADD3_CLAMP;
            end
            CMD_IN5_FROM: begin
                front_next.a = rs - 24'sd3;
                front_next.k = 17'sd54000;
                front_next.off = 16'sd16286;
                front_next.den = DW'(32572);
            end
            CMD_IN5_TO: begin
                front_next.a = vs;
                front_next.k = 17'sd32572;
                front_next.off = 16'sd27000;
                front_next.den = DW'(54000);
                front_next.post = POST_ADD3_CLAMP;
            end
            CMD_DIODE8_FROM: begin
                front_next.a = rs;
                front_next.k = 17'sd10;
            end
            CMD_DIODE10_FROM: begin
                front_next.a = rs;
                front_next.k = 17'sd10;
                front_next.den = DW'(4);
            end
            CMD_DIODE_TO: begin
                front_next.a = vs;
                front_next.k = 17'sd1;
                front_next.off = v[20] ? -16'sd5 : 16'sd5;
                front_next.den = DW'(10);
                front_next.post = POST_CLAMP;
            end
            CMD_THERM_FROM: begin
                front_next.a = 24'sd1012 - rs;
                front_next.k = 17'sd55;
                front_next.off = 16'sd105;
                front_next.den = DW'(210);
            end
            CMD_THERM_TO: begin
                front_next.a = vs;
                front_next.k = 17'sd210;
                front_next.off = 16'sd110;
                front_next.den = DW'(220);
                front_next.post = POST_SUB253_CLAMP;
            end
            CMD_FAN_FROM: begin
                front_next.a = FAN_NUM;
                front_next.k = 17'sd1;
                front_next.den = {14'b0, r} << dc;
                if (r == 10'd0 || r == 10'd255) begin
                    front_next.post = POST_ZERO;
                    front_next.den = DW'(1);
                end
            end
            CMD_FAN_TO: begin
                front_next.a = FAN_NUM + {2'b0, td[22:1]};
                front_next.k = 17'sd1;
                front_next.den = {1'b0, td};
                front_next.post = (v == 21'sd0) ? POST_ZERO : POST_FAN_CLAMP;
            end
            default: begin
                front_next.post = POST_BAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg.valid <= 1'b0;
        end else if (en) begin
            front_reg <= front_next;
        end
    end

    // multiply-add stage
    assign prod = front_reg.a * front_reg.k;

    always_comb begin
        prod_next.valid = front_reg.valid;
        prod_next.n     = {{(NW-41){prod[40]}}, prod}
                        + {{(NW-16){front_reg.off[15]}}, front_reg.off};
        prod_next.den   = front_reg.den;
        prod_next.post  = front_reg.post;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_reg.valid <= 1'b0;
        end else if (en) begin
            prod_reg <= prod_next;
        end
    end

    // magnitude split into the first partial remainder and the numerator bits
    assign mag = prod_reg.n[NW-1] ? (~prod_reg.n + NW'(1)) : prod_reg.n;

    always_comb begin
        chain[0].valid = prod_reg.valid;
        chain[0].rem   = mag[NW-1:QW];
        chain[0].num   = mag[QW-1:0];
        chain[0].quo   = '0;
        chain[0].den   = prod_reg.den;
        chain[0].neg   = prod_reg.n[NW-1];
        chain[0].post  = prod_reg.post;
    end

    // division chain, one quotient bit per cell
    for (genvar i = 0; i < QW; i++) begin : g_cell
        hsuc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    // clamp to a register code range
    function automatic logic [21:0] clamp_code(input logic signed [23:0] x,
                                               input logic signed [23:0] lo);
        logic [21:0] res;
        if (x < lo) begin
            res = 22'(lo);
        end else if (x > 24'sd255) begin
            res = 22'd255;
        end else begin
            res = x[21:0];
        end
        return res;
    endfunction

    // sign, offset and clamp of the quotient
    always_comb begin
        logic signed [23:0] qs;
        qs = chain[QW].neg ? -$signed({3'b0, chain[QW].quo})
                           : $signed({3'b0, chain[QW].quo});
        out_bad_next = 1'b0;
        case (chain[QW].post)
            POST_PLAIN:        out_value_next = qs[21:0];
            POST_ADD3_CLAMP:   out_value_next = clamp_code(qs + 24'sd3, 24'sd0);
            POST_CLAMP:        out_value_next = clamp_code(qs, 24'sd0);
            POST_SUB253_CLAMP: out_value_next = clamp_code(24'sd253 - qs, 24'sd0);
            POST_FAN_CLAMP:    out_value_next = clamp_code(qs, 24'sd1);
            POST_ZERO:         out_value_next = 22'd0;
            POST_BAD: begin
                out_value_next = 22'd0;
                out_bad_next = 1'b1;
            end
            default:           out_value_next = 22'd0;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= chain[QW].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_value_reg <= out_value_next;
            out_bad_reg <= out_bad_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b0, out_value_reg};
    assign m_tuser  = out_bad_reg;

endmodule

// ===== rtl/core/hsuc_checker.sv =====
// port-level checks for the unit converter, bound to the top level
// depends on hsuc_pkg and hwmon_sensor_unit_converter

module hsuc_checker
    import hsuc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [3:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // an unknown command reads as zero
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 24'd0)
        else $error("bad command with nonzero value");

    // no result word right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:22] == 2'b00)
        else $error("padding bits set");

endmodule

bind hwmon_sensor_unit_converter hsuc_checker u_hsuc_checker (.*);

// ===== sim/testbench.sv =====
// self-checking testbench for the hardware-monitor unit converter
// depends on hsuc_pkg and hwmon_sensor_unit_converter

module testbench;
    import hsuc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 24;
    localparam int CYCLE_MAX = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    typedef struct {
        logic signed [21:0] value;
        logic               bad_cmd;
    } conv_result_t;

    conv_result_t pending_results[$];
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int cycles = 0;
    bit stall_enable = 1'b1;

    hwmon_sensor_unit_converter dut (.*);

    always #4 aclk = ~aclk;

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic longint clamp_code(longint x);
        if (x < 0) return 0;
        if (x > 255) return 255;
        return x;
    endfunction

    // compute the expected conversion result
    function automatic conv_result_t convert(logic [3:0] cmd, logic [9:0] raw,
                                             logic signed [20:0] phys, logic [1:0] div_code);
        conv_result_t res;
        longint r, v, d, t, q;
        r = raw;
        v = phys;
        d = longint'(1) << div_code;
        res.bad_cmd = 1'b0;
        q = 0;
        case (cmd)
            CMD_IN_FROM:      q = ((r - 3) * 1000 + 479) / 958;
            CMD_IN_TO:        q = clamp_code((v * 958 + 500) / 1000 + 3);
            CMD_IN5_FROM:     q = ((r - 3) * 54000 + 16286) / 32572;
            CMD_IN5_TO:       q = clamp_code((v * 32572 + 27000) / 54000 + 3);
            CMD_DIODE8_FROM:  q = r * 10;
            CMD_DIODE10_FROM: q = (r * 10) / 4;
            CMD_DIODE_TO:     q = clamp_code(v < 0 ? (v - 5) / 10 : (v + 5) / 10);
            CMD_THERM_FROM:   q = ((253 * 4 - r) * 55 + 105) / 210;
            CMD_THERM_TO:     q = clamp_code(253 - (v * 210 + 110) / 220);
            CMD_FAN_FROM:     q = (r == 0 || r == 255) ? 0 : 1310720 / (r * d);
            CMD_FAN_TO: begin
                if (v == 0) begin
                    q = 0;
                end else begin
                    t = (v < 1) ? 1 : (v > 1000000 ? 1000000 : v);
                    q = (1310720 + t * d / 2) / (t * d);
                    if (q < 1) q = 1;
                    if (q > 255) q = 255;
                end
            end
            default: begin
                q = 0;
                res.bad_cmd = 1'b1;
            end
        endcase
        res.value = q[21:0];
        return res;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on result word %0d: %s got %0d expected %0d",
                 words_checked, what, got, want);
    endtask

    // send one word and record its expected result
    task automatic send_word(logic [3:0] cmd, logic [9:0] raw,
                             logic signed [20:0] phys, logic [1:0] div_code, bit gaps);
        int gap;
        gap = gaps ? random_gap() : 0;
        repeat (gap) @(negedge aclk) s_tvalid <= 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, div_code, phys, raw};
        pending_results.push_back(convert(cmd, raw, phys, div_code));
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        // keep valid high; next call changes data at the falling edge
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        idle_input();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        conv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[21:0], 0);
            end else begin
                want = pending_results.pop_front();
                if ($signed(m_tdata[21:0]) != want.value)
                    report_mismatch("value", $signed(m_tdata[21:0]), want.value);
                if (m_tuser[0] != want.bad_cmd)
                    report_mismatch("bad_cmd", m_tuser[0], want.bad_cmd);
            end
            words_checked++;
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (!stall_enable) m_tready <= 1'b1;
        else if ($urandom_range(0, 99) < 70) m_tready <= 1'b1;
        else if ($urandom_range(0, 19) == 0) m_tready <= 1'b0;
        else m_tready <= ~m_tready;
    end

    // extremes of every field and every command
    task automatic test_directed();
        logic [3:0] c;
        for (int k = 0; k < 16; k++) begin
            c = k[3:0];
            send_word(c, (k % 2) ? 10'h3FF : 10'h000,
                      (k % 2) ? -21'sd1048576 : 21'sd1048575, 2'(k), 1'b0);
        end
        send_word(CMD_FAN_FROM, 10'd255, 21'sd0, 2'd3, 1'b0);
        send_word(CMD_FAN_FROM, 10'd1, 21'sd0, 2'd0, 1'b0);
        send_word(CMD_FAN_TO, 10'd0, 21'sd0, 2'd1, 1'b0);
        send_word(CMD_FAN_TO, 10'd0, -21'sd5, 2'd0, 1'b0);
        send_word(CMD_FAN_TO, 10'd0, 21'sd1000000, 2'd3, 1'b0);
        send_word(CMD_DIODE_TO, 10'd0, -21'sd15, 2'd0, 1'b0);
        send_word(CMD_THERM_FROM, 10'd1023, 21'sd0, 2'd0, 1'b0);
        send_word(CMD_IN_FROM, 10'd0, 21'sd0, 2'd0, 1'b0);
        wait_drained();
    endtask

    // random words: mostly realistic values, some full-range noise
    task automatic test_random(int count);
        logic [3:0] c;
        logic [9:0] r;
        logic signed [20:0] v;
        for (int i = 0; i < count; i++) begin
            c = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(0, 10));
            r = 10'($urandom);
            case ($urandom_range(0, 3))
                0: v = 21'($urandom);
                1: v = 21'($signed(11'($urandom)));
                2: v = 21'($urandom_range(0, 5000));
                default: v = 21'($urandom_range(0, 1000000));
            endcase
            send_word(c, r, v, 2'($urandom), 1'b1);
            // one pause until the pipeline is empty
            if (i == count / 2) wait_drained();
        end
        wait_drained();
    endtask

    // back-to-back input with the output always ready
    task automatic test_full_rate(int count);
        stall_enable = 1'b0;
        for (int i = 0; i < count; i++)
            send_word(4'($urandom_range(0, 10)), 10'($urandom), 21'($urandom),
                      2'($urandom), 1'b0);
        wait_drained();
        stall_enable = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_directed();
        test_random(1000);
        test_full_rate(200);
        repeat (LATENCY + 8) @(posedge aclk);
        $display("covered all eleven conversions, bad commands and field extremes");
        $display("%0d words sent, %0d results checked", words_sent, words_checked);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
